// ===== sv/multilevel_feedback_queue_scheduler_unit_assert.svh =====
// Assertion macros for the multilevel feedback queue scheduler.
// Included by the checker; no other dependencies.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_UNIT_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication
`define MFQS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfqs assertion failed");

// next-cycle implication
`define MFQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfqs assertion failed");

`endif

// ===== sv/mfqs_pkg.sv =====
// Shared constants, codes and control types of the MLFQ scheduler.
// No dependencies.
package mfqs_pkg;

   localparam int TASK_ID_W      = 6;
   localparam int TIME_W         = 32;
   localparam int BURST_W        = 24;
   localparam int QUANTUM_W      = 16;
   localparam int NUM_LEVELS_W   = 4;
   localparam int RUN_LEVEL_W    = 3;
   localparam int MAX_TASKS      = 64;
   localparam int POS_W          = 6;
   localparam int CNT_W          = 7;
   localparam int DEF_MAX_LEVELS = 8;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_LEVELS   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_QUANTUM = 1'd1;

   localparam logic [NUM_LEVELS_W-1:0] NUM_LEVELS_RST   = 4'd3;
   localparam logic [QUANTUM_W-1:0]    BASE_QUANTUM_RST = 16'd2;

   localparam logic OP_ARRIVE   = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   typedef struct packed {
      logic capture;
      logic arrive;
      logic push_held;
      logic scan;
      logic fetch;
      logic calc;
   } mfqs_cmd_type;

   typedef struct packed {
      logic found;
   } mfqs_status_type;

endpackage

// ===== sv/mfqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mfqs_ctrl.sv =====
// Sequencer of the MLFQ scheduler: steps arrive and dispatch beats.
// Depends on mfqs_pkg.
module mfqs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      operation,
   input  mfqs_pkg::mfqs_status_type status,
   output logic                      busy,
   output mfqs_pkg::mfqs_cmd_type    cmd
);
   import mfqs_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_ARRIVE = 6'b000010,
      ST_PUSH   = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_FETCH  = 6'b010000,
      ST_CALC   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = (operation == OP_DISPATCH) ? ST_PUSH : ST_ARRIVE;
            end
         end
         ST_ARRIVE: begin
            cmd.arrive = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_PUSH: begin
            cmd.push_held = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            state_in = status.found ? ST_FETCH : ST_IDLE;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== sv/mfqs_datapath.sv =====
// Datapath of the MLFQ scheduler: config registers, level queues,
// remaining-burst table, clock and slice arithmetic. Uses mfqs_pkg, mfqs_ram.
module mfqs_datapath #(
   parameter int MAX_LEVELS = mfqs_pkg::DEF_MAX_LEVELS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mfqs_pkg::mfqs_cmd_type              cmd,
   output mfqs_pkg::mfqs_status_type           status,
   input  logic [mfqs_pkg::TASK_ID_W-1:0]      req_task_id,
   input  logic [mfqs_pkg::TIME_W-1:0]         req_arrival_time,
   input  logic [mfqs_pkg::BURST_W-1:0]        req_burst_length,
   input  logic                                csr_write_enable,
   input  logic [mfqs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mfqs_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output logic                                rsp_valid,
   output logic [mfqs_pkg::TASK_ID_W-1:0]      rsp_run_id,
   output logic [mfqs_pkg::TIME_W-1:0]         rsp_slice_start,
   output logic [mfqs_pkg::TIME_W-1:0]         rsp_slice_end,
   output logic [mfqs_pkg::RUN_LEVEL_W-1:0]    rsp_run_level,
   output logic                                rsp_finished,
   output logic                                rsp_idle
);
   import mfqs_pkg::*;

   localparam int LVL_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int NLV_W      = NUM_LEVELS_W + 1;
   localparam int FIFO_DEPTH = MAX_LEVELS * MAX_TASKS;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int QUANT_W    = QUANTUM_W + MAX_LEVELS - 1;
   localparam int CMP_W      = (QUANT_W > BURST_W) ? QUANT_W : BURST_W;

   // configuration
   logic [NUM_LEVELS_W-1:0] num_levels_ff;
   logic [QUANTUM_W-1:0]    base_quantum_ff;

   // captured request
   logic [TASK_ID_W-1:0] arr_id_ff;
   logic [TIME_W-1:0]    arr_time_ff;
   logic [BURST_W-1:0]   arr_burst_ff;

   // queue bookkeeping
   logic [POS_W-1:0] head_ff [MAX_LEVELS];
   logic [POS_W-1:0] head_in [MAX_LEVELS];
   logic [CNT_W-1:0] cnt_ff  [MAX_LEVELS];
   logic [CNT_W-1:0] cnt_in  [MAX_LEVELS];

   logic [TIME_W-1:0]    clock_ff, clock_in;
   logic [TASK_ID_W-1:0] held_task_ff, held_task_in;
   logic [LVL_W-1:0]     held_level_ff, held_level_in;
   logic                 held_valid_ff, held_valid_in;

   logic [LVL_W-1:0]     run_lvl_ff;
   logic [TASK_ID_W-1:0] run_id_ff;
   logic [QUANT_W-1:0]   quantum_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TASK_ID_W-1:0]   rsp_run_id_ff;
   logic [TIME_W-1:0]      rsp_slice_start_ff;
   logic [TIME_W-1:0]      rsp_slice_end_ff;
   logic [RUN_LEVEL_W-1:0] rsp_run_level_ff;
   logic                   rsp_finished_ff;
   logic                   rsp_idle_ff;

   logic [LVL_W-1:0]      last_lvl;
   logic [LVL_W-1:0]      target_lvl;
   logic [MAX_LEVELS-1:0] ready_lvl;
   logic [LVL_W-1:0]      scan_lvl;
   logic                  found;
   logic [LVL_W-1:0]      sel_lvl;
   logic [POS_W-1:0]      sel_head;
   logic [CNT_W-1:0]      sel_cnt;
   logic [POS_W-1:0]      tail_pos;
   logic                  push_en;
   logic                  pop_en;

   logic [FIFO_AW-1:0]   fifo_wr_addr, fifo_rd_addr;
   logic [TASK_ID_W-1:0] fifo_wr_data, fifo_rd_data;
   logic                 rem_wr_en;
   logic [TASK_ID_W-1:0] rem_wr_addr;
   logic [BURST_W-1:0]   rem_wr_data, rem_rd_data;

   logic                 quantum_lt;
   logic [BURST_W-1:0]   slice;
   logic [BURST_W-1:0]   new_rem;
   logic [TIME_W:0]      end_sum;
   logic [TIME_W-1:0]    slice_end;

   // ---- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_levels_ff   <= NUM_LEVELS_RST;
         base_quantum_ff <= BASE_QUANTUM_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NUM_LEVELS:   num_levels_ff   <= csr_write_data[NUM_LEVELS_W-1:0];
            CSR_BASE_QUANTUM: base_quantum_ff <= csr_write_data[QUANTUM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---- level selection
   always_comb begin
      if (num_levels_ff == '0) begin
         last_lvl = '0;
      end else if ({1'b0, num_levels_ff} > NLV_W'(MAX_LEVELS)) begin
         last_lvl = LVL_W'(MAX_LEVELS - 1);
      end else begin
         last_lvl = LVL_W'(num_levels_ff - 1'b1);
      end
   end

   assign target_lvl = (held_level_ff >= last_lvl) ? last_lvl
                                                   : LVL_W'({1'b0, held_level_ff} + 1'b1);

   always_comb begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
         ready_lvl[i] = (cnt_ff[i] != '0) && (LVL_W'(i) <= last_lvl);
      end
      scan_lvl = '0;
      for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
         if (ready_lvl[i]) begin
            scan_lvl = LVL_W'(i);
         end
      end
   end

   assign found        = |ready_lvl;
   assign status.found = found;

   always_comb begin
      if (cmd.arrive) begin
         sel_lvl = '0;
      end else if (cmd.push_held) begin
         sel_lvl = target_lvl;
      end else begin
         sel_lvl = scan_lvl;
      end
   end

   assign sel_head = head_ff[sel_lvl];
   assign sel_cnt  = cnt_ff[sel_lvl];
   assign tail_pos = sel_head + sel_cnt[POS_W-1:0];
   assign push_en  = (cmd.arrive || (cmd.push_held && held_valid_ff))
                     && (sel_cnt != CNT_W'(MAX_TASKS));
   assign pop_en   = cmd.scan && found;

   // ---- queue heads and counts
   always_comb begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
         head_in[i] = head_ff[i];
         cnt_in[i]  = cnt_ff[i];
         if (push_en && (sel_lvl == LVL_W'(i))) begin
            cnt_in[i] = cnt_ff[i] + 1'b1;
         end
         if (pop_en && (sel_lvl == LVL_W'(i))) begin
            head_in[i] = head_ff[i] + 1'b1;
            cnt_in[i]  = cnt_ff[i] - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
         if (reset) begin
            head_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end else begin
            head_ff[i] <= head_in[i];
            cnt_ff[i]  <= cnt_in[i];
         end
      end
   end

   // ---- memories
   assign fifo_wr_addr = FIFO_AW'({sel_lvl, tail_pos});
   assign fifo_rd_addr = FIFO_AW'({sel_lvl, sel_head});
   assign fifo_wr_data = cmd.arrive ? arr_id_ff : held_task_ff;

   mfqs_ram #(
      .WIDTH (TASK_ID_W),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (push_en),
      .wr_addr (fifo_wr_addr),
      .wr_data (fifo_wr_data),
      .rd_en   (pop_en),
      .rd_addr (fifo_rd_addr),
      .rd_data (fifo_rd_data)
   );

   assign rem_wr_en   = cmd.arrive || cmd.calc;
   assign rem_wr_addr = cmd.arrive ? arr_id_ff : run_id_ff;
   assign rem_wr_data = cmd.arrive ? arr_burst_ff : new_rem;

   mfqs_ram #(
      .WIDTH (BURST_W),
      .DEPTH (MAX_TASKS)
   ) u_rem_ram (
      .clock   (clock),
      .wr_en   (rem_wr_en),
      .wr_addr (rem_wr_addr),
      .wr_data (rem_wr_data),
      .rd_en   (cmd.fetch),
      .rd_addr (fifo_rd_data),
      .rd_data (rem_rd_data)
   );

   // ---- slice arithmetic
   assign quantum_lt = CMP_W'(quantum_ff) < CMP_W'(rem_rd_data);
   assign slice      = quantum_lt ? BURST_W'(quantum_ff) : rem_rd_data;
   assign new_rem    = rem_rd_data - slice;
   assign end_sum    = {1'b0, clock_ff} + (TIME_W + 1)'(slice);
   assign slice_end  = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];

   // ---- payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         arr_id_ff    <= req_task_id;
         arr_time_ff  <= req_arrival_time;
         arr_burst_ff <= req_burst_length;
      end
      if (pop_en) begin
         run_lvl_ff <= scan_lvl;
      end
      if (cmd.fetch) begin
         run_id_ff  <= fifo_rd_data;
         quantum_ff <= QUANT_W'(base_quantum_ff) << run_lvl_ff;
      end
      if (cmd.calc) begin
         rsp_run_id_ff      <= run_id_ff;
         rsp_slice_start_ff <= clock_ff;
         rsp_slice_end_ff   <= slice_end;
         rsp_run_level_ff   <= RUN_LEVEL_W'(run_lvl_ff);
         rsp_finished_ff    <= (new_rem == '0);
         rsp_idle_ff        <= 1'b0;
      end else if (cmd.scan && !found) begin
         rsp_run_id_ff      <= '0;
         rsp_slice_start_ff <= '0;
         rsp_slice_end_ff   <= '0;
         rsp_run_level_ff   <= '0;
         rsp_finished_ff    <= 1'b0;
         rsp_idle_ff        <= 1'b1;
      end
   end

   // ---- scheduler state
   always_comb begin
      clock_in      = clock_ff;
      held_task_in  = held_task_ff;
      held_level_in = held_level_ff;
      held_valid_in = held_valid_ff;
      rsp_valid_in  = 1'b0;
      if (cmd.arrive && (arr_time_ff > clock_ff)) begin
         clock_in = arr_time_ff;
      end
      if (cmd.push_held) begin
         held_valid_in = 1'b0;
      end
      if (cmd.scan && !found) begin
         rsp_valid_in = 1'b1;
      end
      if (cmd.calc) begin
         clock_in      = slice_end;
         held_task_in  = run_id_ff;
         held_level_in = run_lvl_ff;
         held_valid_in = (new_rem != '0);
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff      <= '0;
         held_task_ff  <= '0;
         held_level_ff <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clock_ff      <= clock_in;
         held_task_ff  <= held_task_in;
         held_level_ff <= held_level_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_run_id      = rsp_run_id_ff;
   assign rsp_slice_start = rsp_slice_start_ff;
   assign rsp_slice_end   = rsp_slice_end_ff;
   assign rsp_run_level   = rsp_run_level_ff;
   assign rsp_finished    = rsp_finished_ff;
   assign rsp_idle        = rsp_idle_ff;

endmodule

// ===== sv/multilevel_feedback_queue_scheduler_unit.sv =====
// Arrive: busy after the accepting edge, and no new beat is taken until it falls.
// Dispatch: rsp_valid strobes after the held-task push, the queue RAM read,
//   the remaining-burst RAM read and the slice update, or after the push and scan
//   when no task is ready; a new start is taken in the cycle rsp_valid is high.
// A new beat is taken in the cycle busy is low; the receiver cannot stall.
// Synchronous active-high reset empties all queues, zeroes time and held
//   task, restores num_levels 3 and base_quantum 2; RAM contents are kept.
module multilevel_feedback_queue_scheduler_unit #(
   parameter int MAX_LEVELS = mfqs_pkg::DEF_MAX_LEVELS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_operation,
   input  logic [mfqs_pkg::TASK_ID_W-1:0]   req_task_id,
   input  logic [mfqs_pkg::TIME_W-1:0]      req_arrival_time,
   input  logic [mfqs_pkg::BURST_W-1:0]     req_burst_length,
   output logic                             rsp_valid,
   output logic [mfqs_pkg::TASK_ID_W-1:0]   rsp_run_id,
   output logic [mfqs_pkg::TIME_W-1:0]      rsp_slice_start,
   output logic [mfqs_pkg::TIME_W-1:0]      rsp_slice_end,
   output logic [mfqs_pkg::RUN_LEVEL_W-1:0] rsp_run_level,
   output logic                             rsp_finished,
   output logic                             rsp_idle,
   input  logic                             csr_write_enable,
   input  logic [mfqs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mfqs_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import mfqs_pkg::*;

   mfqs_cmd_type    cmd;
   mfqs_status_type status;

   mfqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_operation),
      .status    (status),
      .busy      (busy),
      .cmd       (cmd)
   );

   mfqs_datapath #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_task_id      (req_task_id),
      .req_arrival_time (req_arrival_time),
      .req_burst_length (req_burst_length),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_run_id       (rsp_run_id),
      .rsp_slice_start  (rsp_slice_start),
      .rsp_slice_end    (rsp_slice_end),
      .rsp_run_level    (rsp_run_level),
      .rsp_finished     (rsp_finished),
      .rsp_idle         (rsp_idle)
   );

endmodule

// ===== sv/multilevel_feedback_queue_scheduler_unit_checker.sv =====
// Port-level checks of the MLFQ scheduler, bound to the top level.
// Depends on mfqs_pkg and the assertion macro header.
`include "multilevel_feedback_queue_scheduler_unit_assert.svh"

module multilevel_feedback_queue_scheduler_unit_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [mfqs_pkg::TASK_ID_W-1:0]   rsp_run_id,
   input logic [mfqs_pkg::TIME_W-1:0]      rsp_slice_start,
   input logic [mfqs_pkg::TIME_W-1:0]      rsp_slice_end,
   input logic [mfqs_pkg::RUN_LEVEL_W-1:0] rsp_run_level,
   input logic                             rsp_finished,
   input logic                             rsp_idle
);

   `MFQS_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !busy && !rsp_valid)
   `MFQS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `MFQS_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `MFQS_ASSERT_IMPLY(a_idle_zero, clock, reset, rsp_valid && rsp_idle, rsp_run_id == '0 && rsp_slice_start == '0 && rsp_slice_end == '0 && rsp_run_level == '0 && !rsp_finished)
   `MFQS_ASSERT_IMPLY(a_end_order, clock, reset, rsp_valid && !rsp_idle, rsp_slice_end >= rsp_slice_start)

endmodule

bind multilevel_feedback_queue_scheduler_unit multilevel_feedback_queue_scheduler_unit_checker u_checker (.*);

// ===== verif/mfqs_slice_checker.sv =====
`timescale 1ns / 100ps
// Slice checker for the MLFQ scheduler unit: follows accepted command beats and CSR
// writes, predicts every dispatch slice and compares it with the rsp beat.
// Depends on mfqs_pkg.
module mfqs_slice_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic                             req_operation,
   input  logic [mfqs_pkg::TASK_ID_W-1:0]   req_task_id,
   input  logic [mfqs_pkg::TIME_W-1:0]      req_arrival_time,
   input  logic [mfqs_pkg::BURST_W-1:0]     req_burst_length,
   input  logic                             rsp_valid,
   input  logic [mfqs_pkg::TASK_ID_W-1:0]   rsp_run_id,
   input  logic [mfqs_pkg::TIME_W-1:0]      rsp_slice_start,
   input  logic [mfqs_pkg::TIME_W-1:0]      rsp_slice_end,
   input  logic [mfqs_pkg::RUN_LEVEL_W-1:0] rsp_run_level,
   input  logic                             rsp_finished,
   input  logic                             rsp_idle,
   input  logic                             csr_write_enable,
   input  logic [mfqs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mfqs_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                               mismatch_count,
   output int                               slices_owed
);
   import mfqs_pkg::*;

   localparam int LEVELS = DEF_MAX_LEVELS;

   typedef struct packed {
      logic [TASK_ID_W-1:0]   run_id;
      logic [TIME_W-1:0]      slice_start;
      logic [TIME_W-1:0]      slice_end;
      logic [RUN_LEVEL_W-1:0] run_level;
      logic                   finished;
      logic                   idle;
   } slice_type;

   slice_type slices_due[$];

   logic [TASK_ID_W-1:0]    ready_ring [LEVELS][MAX_TASKS];
   int unsigned             ring_head [LEVELS];
   int unsigned             ring_fill [LEVELS];
   logic [BURST_W-1:0]      burst_left [MAX_TASKS];
   logic [TIME_W-1:0]       sched_time;
   logic [TASK_ID_W-1:0]    held_id;
   int unsigned             held_lvl;
   bit                      held_on;
   logic [NUM_LEVELS_W-1:0] cfg_levels;
   logic [QUANTUM_W-1:0]    cfg_quantum;

   function automatic void enqueue_task(int unsigned lvl, logic [TASK_ID_W-1:0] id);
      if (ring_fill[lvl] >= MAX_TASKS) return;
      ready_ring[lvl][(ring_head[lvl] + ring_fill[lvl]) % MAX_TASKS] = id;
      ring_fill[lvl]++;
   endfunction

   function automatic void schedule_beat(logic op, logic [TASK_ID_W-1:0] id,
                                         logic [TIME_W-1:0] t, logic [BURST_W-1:0] burst);
      int unsigned          nlev;
      int unsigned          lvl;
      int unsigned          tgt;
      logic [TASK_ID_W-1:0] pick;
      logic [BURST_W-1:0]   quantum;
      logic [BURST_W-1:0]   slice;
      logic [TIME_W:0]      sum;
      slice_type            r;
      nlev = (cfg_levels == 0) ? 1 : (cfg_levels > LEVELS) ? LEVELS : cfg_levels;
      if (op == OP_ARRIVE) begin
         if (t > sched_time) sched_time = t;
         burst_left[id] = burst;
         enqueue_task(0, id);
         return;
      end
      if (held_on) begin
         tgt = held_lvl + 1;
         if (tgt >= nlev) tgt = nlev - 1;
         enqueue_task(tgt, held_id);
         held_on = 0;
      end
      for (lvl = 0; lvl < nlev; lvl++)
         if (ring_fill[lvl] != 0) break;
      r = '0;
      if (lvl == nlev) begin
         r.idle = 1'b1;
         slices_due.insert(slices_due.size(), r);
         return;
      end
      pick = ready_ring[lvl][ring_head[lvl]];
      ring_head[lvl] = (ring_head[lvl] + 1) % MAX_TASKS;
      ring_fill[lvl]--;
      quantum = {8'd0, cfg_quantum} << lvl;
      slice = (quantum < burst_left[pick]) ? quantum : burst_left[pick];
      burst_left[pick] = burst_left[pick] - slice;
      sum = {1'b0, sched_time} + slice;
      r.slice_start = sched_time;
      r.slice_end = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
      sched_time = r.slice_end;
      if (burst_left[pick] != 0) begin
         held_id = pick;
         held_lvl = lvl;
         held_on = 1;
      end
      r.run_id = pick;
      r.run_level = lvl[RUN_LEVEL_W-1:0];
      r.finished = (burst_left[pick] == 0);
      slices_due.insert(slices_due.size(), r);
   endfunction

   function automatic int field_bad(string name, logic [TIME_W-1:0] want,
                                    logic [TIME_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      slice_type want;
      if (reset) begin
         slices_due.delete();
         for (int i = 0; i < LEVELS; i++) begin
            ring_head[i] = 0;
            ring_fill[i] = 0;
         end
         for (int i = 0; i < MAX_TASKS; i++) burst_left[i] = '0;
         sched_time = '0;
         held_id = '0;
         held_lvl = 0;
         held_on = 0;
         cfg_levels = NUM_LEVELS_RST;
         cfg_quantum = BASE_QUANTUM_RST;
         mismatch_count = 0;
      end else begin
         if (rsp_valid) begin
            if (slices_due.size() == 0) begin
               $error("slice beat with no slice outstanding");
               mismatch_count++;
            end else begin
               want = slices_due.pop_front();
               mismatch_count += field_bad("run_id", want.run_id, rsp_run_id)
                  + field_bad("slice_start", want.slice_start, rsp_slice_start)
                  + field_bad("slice_end", want.slice_end, rsp_slice_end)
                  + field_bad("run_level", want.run_level, rsp_run_level)
                  + field_bad("finished", want.finished, rsp_finished)
                  + field_bad("idle", want.idle, rsp_idle);
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_NUM_LEVELS) cfg_levels = csr_write_data[NUM_LEVELS_W-1:0];
            else if (csr_index == CSR_BASE_QUANTUM) cfg_quantum = csr_write_data;
         end
         if (start && !busy)
            schedule_beat(req_operation, req_task_id, req_arrival_time, req_burst_length);
      end
      slices_owed = slices_due.size();
   end

endmodule

// ===== verif/multilevel_feedback_queue_scheduler_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the MLFQ scheduler unit: clock, reset, CSR settings and
// arrive/dispatch stimulus. Depends on mfqs_pkg, the unit and mfqs_slice_checker.
module multilevel_feedback_queue_scheduler_unit_test;
   import mfqs_pkg::*;

   localparam int DRAIN_CYCLES = 16;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_operation;
   logic [TASK_ID_W-1:0]   req_task_id;
   logic [TIME_W-1:0]      req_arrival_time;
   logic [BURST_W-1:0]     req_burst_length;
   logic                   rsp_valid;
   logic [TASK_ID_W-1:0]   rsp_run_id;
   logic [TIME_W-1:0]      rsp_slice_start;
   logic [TIME_W-1:0]      rsp_slice_end;
   logic [RUN_LEVEL_W-1:0] rsp_run_level;
   logic                   rsp_finished;
   logic                   rsp_idle;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   int                     mismatch_count;
   int                     slices_owed;
   bit                     no_gaps;

   multilevel_feedback_queue_scheduler_unit u_dut (.*);

   mfqs_slice_checker u_check (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [BURST_W-1:0] pick_burst();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 65) return BURST_W'($urandom_range(1, 12));
      if (r < 85) return BURST_W'($urandom_range(13, 2000));
      if (r < 95) return BURST_W'($urandom);
      return {BURST_W{1'b1}};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_levels();
      logic [CSR_DATA_W-1:0] v;
      int                    r;
      v = CSR_DATA_W'($urandom);
      r = $urandom_range(0, 9);
      if (r == 0) v[3:0] = 4'd0;
      else if (r == 1) v[3:0] = 4'($urandom_range(9, 15));
      else v[3:0] = 4'($urandom_range(1, 8));
      return v;
   endfunction

   function automatic logic [QUANTUM_W-1:0] pick_quantum();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r < 6) return QUANTUM_W'($urandom_range(1, 4));
      if (r < 8) return QUANTUM_W'($urandom_range(5, 64));
      return QUANTUM_W'($urandom);
   endfunction

   task automatic idle_for(int n);
      if (n == 0) return;
      @(negedge clock) start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic issue(logic op, logic [TASK_ID_W-1:0] id, logic [TIME_W-1:0] t,
                        logic [BURST_W-1:0] burst);
      if (!no_gaps) idle_for(pick_gap());
      @(negedge clock);
      start <= 1'b1;
      req_operation <= op;
      req_task_id <= id;
      req_arrival_time <= t;
      req_burst_length <= burst;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic dispatch_n(int n);
      repeat (n) issue(OP_DISPATCH, TASK_ID_W'($urandom), $urandom, BURST_W'($urandom));
   endtask

   task automatic wait_drained();
      @(negedge clock) start <= 1'b0;
      while (slices_owed != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock) csr_write_enable <= 1'b0;
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] levels, logic [QUANTUM_W-1:0] quantum);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      write_reg(CSR_NUM_LEVELS, levels);
      write_reg(CSR_BASE_QUANTUM, quantum);
   endtask

   initial begin
      int               sent;
      int               n;
      logic [TIME_W-1:0] gen_time;
      logic [TIME_W-1:0] step;
      start = 1'b0;
      reset = 1'b1;
      req_operation = OP_ARRIVE;
      req_task_id = '0;
      req_arrival_time = '0;
      req_burst_length = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_NUM_LEVELS;
      csr_write_data = '0;
      no_gaps = 0;
      gen_time = '0;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // defaults: empty dispatch, zero and max bursts, duplicate id, bottom level
      dispatch_n(1);
      issue(OP_ARRIVE, 6'd0, 32'd0, 24'd0);
      issue(OP_ARRIVE, 6'd63, 32'd3, 24'd5);
      issue(OP_ARRIVE, 6'd42, 32'd3, {BURST_W{1'b1}});
      dispatch_n(5);
      issue(OP_ARRIVE, 6'd63, 32'd9, 24'd2);
      dispatch_n(2);
      // level count 0 acts as one level, zero quantum
      configure(16'h0000, 16'h0000);
      dispatch_n(2);
      // level count above the maximum, largest quantum
      configure(16'hFFF9, 16'hFFFF);
      dispatch_n(3);
      gen_time = 32'd100;

      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 0) configure(16'h0001, 16'h0001);
         else configure(pick_levels(), pick_quantum());
         no_gaps = (phase % 4 == 1);
         if (phase == 4) begin
            // overflow level 0, then work it down
            repeat (70) begin
               gen_time = gen_time + $urandom_range(0, 3);
               issue(OP_ARRIVE, TASK_ID_W'($urandom), gen_time, pick_burst());
            end
            dispatch_n(30);
         end
         sent = 0;
         while (sent < 100) begin
            if ($urandom_range(0, 99) < 85) begin
               n = $urandom_range(0, 4);
               sent += n;
               repeat (n) begin
                  step = $urandom_range(0, 25);
                  gen_time = (gen_time > ~step) ? {TIME_W{1'b1}} : gen_time + step;
                  issue(OP_ARRIVE, TASK_ID_W'($urandom), gen_time, pick_burst());
               end
               n = $urandom_range(1, 6);
               dispatch_n(n);
               sent += n;
            end else begin
               issue(logic'($urandom), TASK_ID_W'($urandom), $urandom, BURST_W'($urandom));
               sent++;
            end
            if ($urandom_range(0, 29) == 0) wait_drained();
         end
      end

      // time saturation at the top of the range
      configure(16'h0008, 16'hFFFF);
      issue(OP_ARRIVE, 6'd5, 32'hFFFF_FF00, {BURST_W{1'b1}});
      issue(OP_ARRIVE, 6'd6, {TIME_W{1'b1}}, 24'h80_0000);
      dispatch_n(4);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && slices_owed == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== multilevel_feedback_queue_scheduler_unit.f =====
+incdir+sv
sv/mfqs_pkg.sv
sv/mfqs_ram.sv
sv/mfqs_ctrl.sv
sv/mfqs_datapath.sv
sv/multilevel_feedback_queue_scheduler_unit.sv
sv/multilevel_feedback_queue_scheduler_unit_checker.sv
verif/mfqs_slice_checker.sv
verif/multilevel_feedback_queue_scheduler_unit_test.sv
